FILE: src/cma_pkg.sv
// Shared types and constants for the central moment accumulator.
package cma_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int DEV_W       = 33;
    localparam int MOMENT_W    = 64;
    localparam int DEG_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 17;
    localparam int PROD_W      = 96;

    // Configuration register indexes.
    localparam logic REG_MEAN   = 1'b0;
    localparam logic REG_DEGREE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEGREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT    = 2'd2;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POW_START,
        S_POW_WAIT,
        S_ACCUM,
        S_FINISH,
        S_DIV_WAIT,
        S_DELIVER
    } seq_state_t;

    // Status returned by the shared multiply unit.
    typedef struct packed {
        logic done;
        logic ovf;
    } mul_stat_t;

endpackage

FILE: src/cma_qmul.sv
// Shared fixed-point multiply step: two 32x32 partial products and a saturating combine.
module cma_qmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [cma_pkg::MOMENT_W-1:0]   a,
    input  logic signed [cma_pkg::DEV_W-1:0]      b,
    output cma_pkg::mul_stat_t                    stat,
    output logic signed [cma_pkg::MOMENT_W-1:0]   result
);

    logic [1:0]                        phase_reg;
    logic [1:0]                        phase_next;
    logic [cma_pkg::MOMENT_W-1:0]      x_reg;
    logic [31:0]                       y_reg;
    logic                              neg_reg;
    logic [63:0]                       plo_reg;
    logic [63:0]                       phi_reg;
    logic [cma_pkg::MOMENT_W-1:0]      a_mag;
    logic [cma_pkg::DEV_W-1:0]         b_mag;
    logic [31:0]                       x_part;
    logic [63:0]                       part_prod;
    logic [cma_pkg::PROD_W-1:0]        full;
    logic [cma_pkg::PROD_W-1:0]        shifted;
    logic [63:0]                       r;
    logic                              big;

    assign a_mag = a[cma_pkg::MOMENT_W-1] ? (~a + 1'b1) : a;
    assign b_mag = b[cma_pkg::DEV_W-1] ? (~b + 1'b1) : b;

    // One 32x32 multiplier serves both halves of the power operand in turn.
    assign x_part    = (phase_reg == 2'd1) ? x_reg[31:0] : x_reg[63:32];
    assign part_prod = 64'(x_part) * 64'(y_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == 2'd0)
        begin
            if (start)
                phase_next = 2'd1;
        end
        else
        begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 2'd0;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == 2'd0 && start)
        begin
            x_reg   <= a_mag;
            y_reg   <= b_mag[31:0];
            neg_reg <= a[cma_pkg::MOMENT_W-1] ^ b[cma_pkg::DEV_W-1];
        end
        if (phase_reg == 2'd1)
            plo_reg <= part_prod;
        if (phase_reg == 2'd2)
            phi_reg <= part_prod;
    end

    // Combine the partial products, drop the fraction, then saturate.
    always_comb
    begin
        full    = {phi_reg, 32'd0} + {32'd0, plo_reg};
        shifted = full >> FRAC_BITS;
        r       = shifted[63:0];
        big     = |shifted[cma_pkg::PROD_W-1:64];
        stat.ovf = 1'b0;
        if (neg_reg)
        begin
            if (big || r > 64'h8000_0000_0000_0000)
            begin
                stat.ovf = 1'b1;
                result   = 64'sh8000_0000_0000_0000;
            end
            else
            begin
                result = $signed(~r + 64'd1);
            end
        end
        else
        begin
            if (big || r[63])
            begin
                stat.ovf = 1'b1;
                result   = 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            else
            begin
                result = $signed(r);
            end
        end
        stat.done = (phase_reg == 2'd3);
    end

endmodule

FILE: src/cma_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned count.
module cma_div #(
    parameter int CNT_W = 17
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [cma_pkg::MOMENT_W-1:0]   dividend,
    input  logic [CNT_W-1:0]                      divisor,
    output logic                                  done,
    output logic signed [cma_pkg::MOMENT_W-1:0]   quotient
);

    localparam int ITER_W = $clog2(cma_pkg::MOMENT_W + 1);

    logic                              busy_reg;
    logic [ITER_W-1:0]                 iter_reg;
    logic                              done_reg;
    logic [cma_pkg::MOMENT_W-1:0]      q_reg;
    logic [CNT_W-1:0]                  rem_reg;
    logic [CNT_W-1:0]                  dvs_reg;
    logic                              neg_reg;
    logic [CNT_W:0]                    trial;
    logic                              fits;

    assign trial = {rem_reg, q_reg[cma_pkg::MOMENT_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (iter_reg == ITER_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(cma_pkg::MOMENT_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[cma_pkg::MOMENT_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[cma_pkg::MOMENT_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            q_reg   <= {q_reg[cma_pkg::MOMENT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

endmodule

FILE: src/central_moment_accumulator.sv
// Central moment accumulator: sequencer, set state and result register.
// A new sample is taken only when the sequencer is idle; its deviation is raised to the
// degree-th power by passes of the shared multiply unit (two 32x32 partial products and a combine).
// A last sample adds a close step, a bit-serial divide and a load of the result;
// at degree zero there is no divide.
// Reset (asynchronous, active low) sets mean 0, degree 2 and clears sum, count and flags.
module central_moment_accumulator #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_LIMIT = 65536
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic                                     cfg_index,
    input  logic [31:0]                              cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [cma_pkg::SAMPLE_W-1:0]      sample,
    input  logic                                     last,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [cma_pkg::MOMENT_W-1:0]      moment,
    output logic [cma_pkg::STATUS_W-1:0]             status,
    output logic [cma_pkg::COUNT_OUT_W-1:0]          sample_count
);

    localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(COUNT_LIMIT);

    cma_pkg::seq_state_t                      state_reg;
    cma_pkg::seq_state_t                      state_next;

    // Configuration registers.
    logic signed [cma_pkg::SAMPLE_W-1:0]      mean_reg;
    logic [cma_pkg::DEG_W-1:0]                degree_reg;

    // Per-sample working registers.
    logic signed [cma_pkg::DEV_W-1:0]         dev_reg;
    logic signed [cma_pkg::MOMENT_W-1:0]      pow_reg;
    logic [cma_pkg::DEG_W-1:0]                deg_left_reg;
    logic [cma_pkg::DEG_W-1:0]                deg_cur_reg;
    logic                                     last_reg;

    // Set state.
    logic signed [cma_pkg::MOMENT_W-1:0]      sum_reg;
    logic [CNT_W-1:0]                         count_reg;
    logic                                     ovf_reg;

    // Result waiting for the divider, and the output register.
    logic [cma_pkg::STATUS_W-1:0]             res_status_reg;
    logic [CNT_W-1:0]                         res_count_reg;
    logic signed [cma_pkg::MOMENT_W-1:0]      res_moment_reg;
    logic                                     out_valid_reg;
    logic signed [cma_pkg::MOMENT_W-1:0]      moment_reg;
    logic [cma_pkg::STATUS_W-1:0]             status_reg;
    logic [CNT_W+cma_pkg::COUNT_OUT_W-1:0]    count_wide;
    logic [cma_pkg::COUNT_OUT_W-1:0]          count_out_reg;

    // Control decoded from the state.
    logic                                     in_take;
    logic                                     mul_start;
    logic                                     div_start;
    logic                                     out_free;
    logic                                     out_load;

    cma_pkg::mul_stat_t                       mul_stat;
    logic signed [cma_pkg::MOMENT_W-1:0]      mul_result;
    logic                                     div_done;
    logic signed [cma_pkg::MOMENT_W-1:0]      div_quot;
    logic signed [cma_pkg::MOMENT_W:0]        sum_ext;
    logic                                     sum_sat;

    cma_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (pow_reg),
        .b      (dev_reg),
        .stat   (mul_stat),
        .result (mul_result)
    );

    cma_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // A finished result may be loaded when the output register is empty or being taken.
    assign out_free = !out_valid_reg || !out_stall;

    // The accumulator adds one extra bit so that overflow shows as a sign mismatch.
    assign sum_ext = {sum_reg[cma_pkg::MOMENT_W-1], sum_reg}
                   + {pow_reg[cma_pkg::MOMENT_W-1], pow_reg};
    assign sum_sat = (sum_ext[cma_pkg::MOMENT_W] != sum_ext[cma_pkg::MOMENT_W-1]);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cma_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = (degree_reg == '0) ? cma_pkg::S_ACCUM : cma_pkg::S_POW_START;
            end
            cma_pkg::S_POW_START:
                state_next = cma_pkg::S_POW_WAIT;
            cma_pkg::S_POW_WAIT:
            begin
                if (mul_stat.done)
                    state_next = (deg_left_reg == cma_pkg::DEG_W'(1)) ?
                                 cma_pkg::S_ACCUM : cma_pkg::S_POW_START;
            end
            cma_pkg::S_ACCUM:
                state_next = last_reg ? cma_pkg::S_FINISH : cma_pkg::S_IDLE;
            cma_pkg::S_FINISH:
                state_next = (deg_cur_reg == '0) ? cma_pkg::S_DELIVER : cma_pkg::S_DIV_WAIT;
            cma_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = cma_pkg::S_DELIVER;
            end
            cma_pkg::S_DELIVER:
            begin
                if (out_free)
                    state_next = cma_pkg::S_IDLE;
            end
            default:
                state_next = cma_pkg::S_IDLE;
        endcase
    end

    // Output and strobe logic.
    always_comb
    begin
        in_take   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            cma_pkg::S_IDLE:      in_take   = in_valid;
            cma_pkg::S_POW_START: mul_start = 1'b1;
            cma_pkg::S_FINISH:    div_start = (deg_cur_reg != '0);
            cma_pkg::S_DELIVER:   out_load  = out_free;
            default:              in_take   = 1'b0;
        endcase
    end

    assign in_stall = (state_reg != cma_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cma_pkg::S_IDLE;
            mean_reg      <= '0;
            degree_reg    <= cma_pkg::DEG_W'(2);
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    cma_pkg::REG_MEAN:   mean_reg   <= $signed(cfg_data);
                    cma_pkg::REG_DEGREE: degree_reg <= cfg_data[cma_pkg::DEG_W-1:0];
                    default:             mean_reg   <= mean_reg;
                endcase
            end

            if (mul_stat.done && mul_stat.ovf)
                ovf_reg <= 1'b1;

            // Saturating add of the powered deviation, and the sample count.
            if (state_reg == cma_pkg::S_ACCUM)
            begin
                if (sum_sat)
                    sum_reg <= sum_ext[cma_pkg::MOMENT_W] ?
                               64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
                else
                    sum_reg <= sum_ext[cma_pkg::MOMENT_W-1:0];
                // A saturated sum or a sample past the count limit both mark the set.
                if (sum_sat || count_reg >= MAX_CNT)
                    ovf_reg <= 1'b1;
                if (count_reg < MAX_CNT)
                    count_reg <= count_reg + 1'b1;
            end

            // The divider takes the sum and count at this edge if degree > 0, so the set restarts.
            if (state_reg == cma_pkg::S_FINISH)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end

            out_valid_reg <= (out_valid_reg && out_stall) || out_load;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dev_reg      <= cma_pkg::DEV_W'(sample) - cma_pkg::DEV_W'(mean_reg);
            pow_reg      <= cma_pkg::MOMENT_W'(64'd1 << FRAC_BITS);
            deg_left_reg <= degree_reg;
            deg_cur_reg  <= degree_reg;
            last_reg     <= last;
        end

        if (state_reg == cma_pkg::S_POW_WAIT && mul_stat.done)
        begin
            pow_reg      <= mul_result;
            deg_left_reg <= deg_left_reg - 1'b1;
        end

        if (state_reg == cma_pkg::S_FINISH)
        begin
            res_count_reg <= count_reg;
            if (deg_cur_reg == '0)
            begin
                res_moment_reg <= '0;
                res_status_reg <= cma_pkg::ST_DEGREE;
            end
            else
            begin
                res_status_reg <= ovf_reg ? cma_pkg::ST_SAT : cma_pkg::ST_OK;
            end
        end

        if (state_reg == cma_pkg::S_DIV_WAIT && div_done)
            res_moment_reg <= div_quot;

        if (out_load)
        begin
            moment_reg    <= res_moment_reg;
            status_reg    <= res_status_reg;
            count_out_reg <= count_wide[cma_pkg::COUNT_OUT_W-1:0];
        end
    end

    // The reported count keeps only its low bits.
    assign count_wide = {{cma_pkg::COUNT_OUT_W{1'b0}}, res_count_reg};

    assign out_valid    = out_valid_reg;
    assign moment       = moment_reg;
    assign status       = status_reg;
    assign sample_count = count_out_reg;

endmodule
